// ===== rtl/core/kvrl_pkg.sv =====
// kvrl_pkg: shared types and constants for the key/velocity region lookup.
// Used by kvrl_ctrl, kvrl_dp and key_velocity_region_lookup; no dependencies.
package kvrl_pkg;

  localparam int unsigned KEY_W   = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ENTRY_W = 4 * KEY_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic load_query;
    logic issue;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_issue;
  } dp_sts_t;

endpackage

// ===== rtl/core/kvrl_ram.sv =====
// kvrl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvrl_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/kvrl_ctrl.sv =====
// kvrl_ctrl: controller state machine for the region lookup.
// Depends on kvrl_pkg; drives kvrl_dp through dp_cmd_t, reads dp_sts_t.
module kvrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              operation,
  input  kvrl_pkg::dp_sts_t sts,
  output kvrl_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);

  kvrl_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign accept = start && (state_r == kvrl_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd.wr_en      = 1'b0;
    cmd.load_query = 1'b0;
    cmd.issue      = 1'b0;
    unique case (state_r)
      kvrl_pkg::ST_IDLE: begin
        if (accept && (operation == kvrl_pkg::OP_WRITE)) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.load_query = 1'b1;
          state_nxt      = sts.empty ? kvrl_pkg::ST_RESP : kvrl_pkg::ST_SCAN;
        end
      end
      kvrl_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = kvrl_pkg::ST_DRAIN;
        end
      end
      kvrl_pkg::ST_DRAIN: begin
        state_nxt = kvrl_pkg::ST_RESP;
      end
      kvrl_pkg::ST_RESP: begin
        state_nxt = kvrl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kvrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != kvrl_pkg::ST_IDLE);
  assign out_valid = (state_r == kvrl_pkg::ST_RESP);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(operation) == kvrl_pkg::OP_QUERY)
    else $error("busy rose without an accepted query");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> !busy)
    else $error("write transfer left the block busy");

endmodule

// ===== rtl/core/kvrl_dp.sv =====
// kvrl_dp: region table, count register and the scan datapath that tracks the
// first exact match and the first nearest key. Depends on kvrl_pkg, kvrl_ram.
module kvrl_dp #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kvrl_pkg::dp_cmd_t          cmd,
  output kvrl_pkg::dp_sts_t          sts,
  input  logic                       cfg_valid,
  input  logic [kvrl_pkg::KEY_W-1:0] cfg_region_count,
  input  logic [kvrl_pkg::IDX_W-1:0] entry_index,
  input  logic [kvrl_pkg::KEY_W-1:0] low_key,
  input  logic [kvrl_pkg::KEY_W-1:0] high_key,
  input  logic [kvrl_pkg::KEY_W-1:0] low_vel,
  input  logic [kvrl_pkg::KEY_W-1:0] high_vel,
  input  logic [kvrl_pkg::KEY_W-1:0] note,
  input  logic [kvrl_pkg::KEY_W-1:0] velocity,
  output logic                       found,
  output logic                       exact,
  output logic [kvrl_pkg::IDX_W-1:0] region_index,
  output logic [kvrl_pkg::KEY_W-1:0] key_distance
);

  localparam int unsigned AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_B = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CNT_W = (CNT_B > kvrl_pkg::KEY_W) ? CNT_B : kvrl_pkg::KEY_W;
  localparam int unsigned KW    = kvrl_pkg::KEY_W;

  logic [KW-1:0]    count_r;
  logic [CNT_W-1:0] count_ext, n_clamp;
  logic [CNT_W-1:0] n_r, cnt_r;
  logic [KW-1:0]    note_r, vel_r;
  logic             eval_valid_r;
  logic [AW-1:0]    eval_idx_r;
  logic             found_r, exact_r;
  logic [AW-1:0]    best_idx_r;
  logic [KW-1:0]    best_dist_r;

  logic [CNT_W-1:0]            wr_idx_ext;
  logic                        wr_ok;
  logic [kvrl_pkg::ENTRY_W-1:0] wr_entry, rd_entry;
  logic [KW-1:0]               e_lo_key, e_hi_key, e_lo_vel, e_hi_vel;
  logic                        below, above, vel_in, hit;
  logic [KW-1:0]               key_gap;

  // count register, clamped to the table depth
  assign count_ext = CNT_W'(count_r);
  assign n_clamp   = (count_ext > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : count_ext;
  assign sts.empty      = (n_clamp == '0);
  assign sts.last_issue = ((cnt_r + CNT_W'(1)) == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_region_count;
    end
  end

  // table
  assign wr_idx_ext = CNT_W'(entry_index);
  assign wr_ok      = cmd.wr_en && (wr_idx_ext < CNT_W'(MAX_REGIONS));
  assign wr_entry   = {low_key, high_key, low_vel, high_vel};

  kvrl_ram #(
    .WIDTH (kvrl_pkg::ENTRY_W),
    .DEPTH (MAX_REGIONS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_idx_ext[AW-1:0]),
    .wdata (wr_entry),
    .re    (cmd.issue),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rd_entry)
  );

  // entry test
  assign {e_lo_key, e_hi_key, e_lo_vel, e_hi_vel} = rd_entry;
  assign below  = (note_r < e_lo_key);
  assign above  = (note_r > e_hi_key);
  assign vel_in = (vel_r >= e_lo_vel) && (vel_r <= e_hi_vel);
  assign hit    = !below && !above && vel_in;
  always_comb begin
    priority if (below) begin
      key_gap = e_lo_key - note_r;
    end else if (above) begin
      key_gap = note_r - e_hi_key;
    end else begin
      key_gap = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_valid_r <= 1'b0;
      found_r      <= 1'b0;
      exact_r      <= 1'b0;
      cnt_r        <= '0;
    end else begin
      eval_valid_r <= cmd.issue;
      if (cmd.load_query) begin
        found_r <= 1'b0;
        exact_r <= 1'b0;
        cnt_r   <= '0;
      end else begin
        if (cmd.issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (eval_valid_r && !exact_r) begin
          if (hit) begin
            found_r <= 1'b1;
            exact_r <= 1'b1;
          end else if (!found_r || (key_gap < best_dist_r)) begin
            found_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      note_r      <= note;
      vel_r       <= velocity;
      n_r         <= n_clamp;
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (eval_valid_r && !exact_r) begin
      if (hit) begin
        best_idx_r  <= eval_idx_r;
        best_dist_r <= '0;
      end else if (!found_r || (key_gap < best_dist_r)) begin
        best_idx_r  <= eval_idx_r;
        best_dist_r <= key_gap;
      end
    end
    if (cmd.issue) begin
      eval_idx_r <= cnt_r[AW-1:0];
    end
  end

  assign found        = found_r;
  assign exact        = exact_r;
  assign region_index = kvrl_pkg::IDX_W'(best_idx_r);
  assign key_distance = best_dist_r;

  a_exact_found: assert property (@(posedge clk) disable iff (!rst_n)
    exact_r |-> found_r && (best_dist_r == '0))
    else $error("exact match without found or with nonzero distance");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cnt_r < n_r))
    else $error("read issued beyond the searched count");

  a_eval_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    eval_valid_r |-> $past(cmd.issue))
    else $error("entry evaluated without a read");

endmodule

// ===== rtl/core/key_velocity_region_lookup.sv =====
// key_velocity_region_lookup: top level; a write transfer stores one region and
// never raises busy. A query scans N table entries, N being region_count clamped to
// MAX_REGIONS: one table read per cycle, then the drain and result states, the strobe
// in the result state (N = 0: strobe in the cycle after the start); a new query is
// accepted only after the strobe. The receiver cannot stall. Synchronous reset clears the
// count and control, not the table. Depends on kvrl_pkg, kvrl_ctrl, kvrl_dp, kvrl_ram.
module key_velocity_region_lookup #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [kvrl_pkg::IDX_W-1:0] in_entry_index,
  input  logic [kvrl_pkg::KEY_W-1:0] in_low_key,
  input  logic [kvrl_pkg::KEY_W-1:0] in_high_key,
  input  logic [kvrl_pkg::KEY_W-1:0] in_low_vel,
  input  logic [kvrl_pkg::KEY_W-1:0] in_high_vel,
  input  logic [kvrl_pkg::KEY_W-1:0] in_note,
  input  logic [kvrl_pkg::KEY_W-1:0] in_velocity,
  output logic                       out_valid,
  output logic                       out_found,
  output logic                       out_exact,
  output logic [kvrl_pkg::IDX_W-1:0] out_region_index,
  output logic [kvrl_pkg::KEY_W-1:0] out_key_distance,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kvrl_pkg::KEY_W-1:0] cfg_region_count
);

  kvrl_pkg::dp_cmd_t cmd;
  kvrl_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  kvrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  kvrl_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_region_count (cfg_region_count),
    .entry_index      (in_entry_index),
    .low_key          (in_low_key),
    .high_key         (in_high_key),
    .low_vel          (in_low_vel),
    .high_vel         (in_high_vel),
    .note             (in_note),
    .velocity         (in_velocity),
    .found            (out_found),
    .exact            (out_exact),
    .region_index     (out_region_index),
    .key_distance     (out_key_distance)
  );

endmodule

// ===== dv/key_velocity_region_lookup_tb.sv =====
// Self-checking testbench for key_velocity_region_lookup: region writes and key/velocity
// queries checked against a behavioral table search kept in a scoreboard class.
// Depends on kvrl_pkg and the key_velocity_region_lookup RTL only.
`timescale 1ns / 100ps

module key_velocity_region_lookup_tb;

  localparam int unsigned MAX_REGIONS = 64;

  typedef struct packed {
    logic                       op;
    logic [kvrl_pkg::IDX_W-1:0] entry;
    logic [kvrl_pkg::KEY_W-1:0] lo_key;
    logic [kvrl_pkg::KEY_W-1:0] hi_key;
    logic [kvrl_pkg::KEY_W-1:0] lo_vel;
    logic [kvrl_pkg::KEY_W-1:0] hi_vel;
    logic [kvrl_pkg::KEY_W-1:0] note;
    logic [kvrl_pkg::KEY_W-1:0] vel;
  } region_item_t;

  typedef struct packed {
    logic                       found;
    logic                       exact;
    logic [kvrl_pkg::IDX_W-1:0] region;
    logic [kvrl_pkg::KEY_W-1:0] distance;
  } lookup_t;

  class lookup_scoreboard;
    localparam int unsigned DEPTH = 64;

    logic [kvrl_pkg::KEY_W-1:0] lo_key[DEPTH];
    logic [kvrl_pkg::KEY_W-1:0] hi_key[DEPTH];
    logic [kvrl_pkg::KEY_W-1:0] lo_vel[DEPTH];
    logic [kvrl_pkg::KEY_W-1:0] hi_vel[DEPTH];
    int unsigned region_count;
    lookup_t     pending_lookups[$];
    int unsigned mismatches;
    int unsigned writes;
    int unsigned queries;
    int unsigned exact_hits;
    int unsigned fallbacks;
    int unsigned empties;

    function new();
      region_count = 0;
      mismatches   = 0;
      writes       = 0;
      queries      = 0;
      exact_hits   = 0;
      fallbacks    = 0;
      empties      = 0;
    endfunction

    function void set_count(logic [kvrl_pkg::KEY_W-1:0] value);
      region_count = value;
    endfunction

    // first exact match in index order, else lowest-index nearest key range
    function lookup_t nearest_region(logic [kvrl_pkg::KEY_W-1:0] note,
                                     logic [kvrl_pkg::KEY_W-1:0] vel);
      lookup_t     r;
      int unsigned span;
      int unsigned best;
      int unsigned gap;
      r    = '0;
      span = (region_count > DEPTH) ? DEPTH : region_count;
      best = 1 << 20;
      for (int i = 0; i < span; i++) begin
        if (note >= lo_key[i] && note <= hi_key[i] &&
            vel >= lo_vel[i] && vel <= hi_vel[i]) begin
          r.found  = 1'b1;
          r.exact  = 1'b1;
          r.region = 6'(i);
          return r;
        end
      end
      for (int i = 0; i < span; i++) begin
        if (note < lo_key[i]) gap = lo_key[i] - note;
        else if (note > hi_key[i]) gap = note - hi_key[i];
        else gap = 0;
        if (gap < best) begin
          best       = gap;
          r.found    = 1'b1;
          r.region   = 6'(i);
          r.distance = 7'(gap);
        end
      end
      return r;
    endfunction

    function void note_transfer(region_item_t it);
      if (it.op == kvrl_pkg::OP_WRITE) begin
        lo_key[it.entry] = it.lo_key;
        hi_key[it.entry] = it.hi_key;
        lo_vel[it.entry] = it.lo_vel;
        hi_vel[it.entry] = it.hi_vel;
        writes++;
      end else begin
        pending_lookups = {pending_lookups, nearest_region(it.note, it.vel)};
        queries++;
      end
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                 $time, got.found, got.exact, got.region, got.distance);
        mismatches++;
        return;
      end
      want = pending_lookups.pop_front();
      report_field("found", want.found, got.found);
      report_field("exact", want.exact, got.exact);
      report_field("region_index", want.region, got.region);
      report_field("key_distance", want.distance, got.distance);
      if (!want.found) empties++;
      else if (want.exact) exact_hits++;
      else fallbacks++;
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_operation = 1'b0;
  logic [kvrl_pkg::IDX_W-1:0] in_entry_index = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_low_key = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_high_key = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_low_vel = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_high_vel = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_note = '0;
  logic [kvrl_pkg::KEY_W-1:0] in_velocity = '0;
  logic                       out_valid;
  logic                       out_found;
  logic                       out_exact;
  logic [kvrl_pkg::IDX_W-1:0] out_region_index;
  logic [kvrl_pkg::KEY_W-1:0] out_key_distance;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [kvrl_pkg::KEY_W-1:0] cfg_region_count = '0;

  lookup_scoreboard sb;
  int unsigned      idle_pct = 0;

  key_velocity_region_lookup #(
    .MAX_REGIONS(MAX_REGIONS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_low_key       (in_low_key),
    .in_high_key      (in_high_key),
    .in_low_vel       (in_low_vel),
    .in_high_vel      (in_high_vel),
    .in_note          (in_note),
    .in_velocity      (in_velocity),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_exact        (out_exact),
    .out_region_index (out_region_index),
    .out_key_distance (out_key_distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_region_count (cfg_region_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_lookup('{out_found, out_exact, out_region_index, out_key_distance});
    end
  end

  initial begin
    #15_000_000;
    $display("key_velocity_region_lookup_tb NOT OK");
    $finish;
  end

  function automatic region_item_t rand_bits();
    region_item_t it;
    it.op     = 1'($urandom);
    it.entry  = 6'($urandom);
    it.lo_key = 7'($urandom);
    it.hi_key = 7'($urandom);
    it.lo_vel = 7'($urandom);
    it.hi_vel = 7'($urandom);
    it.note   = 7'($urandom);
    it.vel    = 7'($urandom);
    return it;
  endfunction

  function automatic region_item_t make_write(int unsigned entry, int unsigned lk, int unsigned hk,
                                              int unsigned lv, int unsigned hv);
    region_item_t it;
    it        = rand_bits();
    it.op     = kvrl_pkg::OP_WRITE;
    it.entry  = 6'(entry);
    it.lo_key = 7'(lk);
    it.hi_key = 7'(hk);
    it.lo_vel = 7'(lv);
    it.hi_vel = 7'(hv);
    return it;
  endfunction

  function automatic region_item_t make_query(int unsigned note, int unsigned vel);
    region_item_t it;
    it      = rand_bits();
    it.op   = kvrl_pkg::OP_QUERY;
    it.note = 7'(note);
    it.vel  = 7'(vel);
    return it;
  endfunction

  // mostly narrow key splits over velocity layers, some fully random or inverted
  function automatic region_item_t rand_write(int unsigned span);
    int unsigned entry;
    int unsigned lk;
    int unsigned hk;
    int unsigned lv;
    int unsigned hv;
    int unsigned pick;
    entry = (span > 0 && $urandom_range(99) < 60) ? $urandom_range(span - 1)
                                                   : $urandom_range(63);
    pick  = $urandom_range(99);
    if (pick < 30) begin
      lk = $urandom_range(127);
      hk = $urandom_range(127);
      lv = $urandom_range(127);
      hv = $urandom_range(127);
    end else begin
      lk = $urandom_range(127);
      hk = lk + $urandom_range(24);
      lv = $urandom_range(127);
      hv = lv + $urandom_range(63);
      if (hk > 127) hk = 127;
      if (hv > 127) hv = 127;
      if (pick >= 90) begin
        {lk, hk} = {hk, lk};
        if (pick >= 95) {lv, hv} = {hv, lv};
      end
    end
    return make_write(entry, lk, hk, lv, hv);
  endfunction

  function automatic region_item_t rand_query(int unsigned span);
    int unsigned note;
    int unsigned vel;
    int unsigned e;
    int unsigned pick;
    note = $urandom_range(127);
    if (span > 0 && $urandom_range(99) < 50) begin
      e = $urandom_range(span - 1);
      if (sb.lo_key[e] <= sb.hi_key[e]) note = $urandom_range(sb.hi_key[e], sb.lo_key[e]);
    end
    pick = $urandom_range(99);
    if (pick < 8) vel = 0;
    else if (pick < 14) vel = 127;
    else if (pick < 20) vel = 1;
    else vel = $urandom_range(127, 1);
    return make_query(note, vel);
  endfunction

  task automatic send(region_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= it.op;
    in_entry_index <= it.entry;
    in_low_key     <= it.lo_key;
    in_high_key    <= it.hi_key;
    in_low_vel     <= it.lo_vel;
    in_high_vel    <= it.hi_vel;
    in_note        <= it.note;
    in_velocity    <= it.vel;
    do @(posedge clk); while (busy);
    sb.note_transfer(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_region_count(int unsigned value);
    drain();
    cfg_valid        <= 1'b1;
    cfg_region_count <= 7'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(7'(value));
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle, int unsigned n_items,
                           int unsigned drain_every);
    int unsigned span;
    load_region_count(count);
    idle_pct = idle;
    span     = (count > MAX_REGIONS) ? MAX_REGIONS : count;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 25) send(rand_write(span));
      else send(rand_query(span));
      if (drain_every != 0 && (k + 1) % drain_every == 0) drain();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table search at the reset count
    send(make_query(127, 127));
    send(make_query(0, 0));

    send(make_write(0, 60, 72, 1, 63));
    send(make_write(1, 60, 72, 64, 127));
    send(make_write(2, 100, 20, 0, 127));   // inverted key range
    send(make_write(3, 127, 127, 0, 0));
    send(make_write(63, 0, 0, 127, 127));
    load_region_count(4);
    send(make_query(64, 30));
    send(make_query(64, 100));
    send(make_query(64, 0));
    send(make_query(127, 0));
    send(make_query(0, 127));
    send(make_query(110, 50));
    send(make_query(50, 127));
    send(make_query(20, 1));

    for (int i = 0; i < MAX_REGIONS; i++) begin
      region_item_t it;
      it       = rand_write(0);
      it.entry = 6'(i);
      send(it);
    end

    run_phase(64, 0, 150, 0);
    run_phase(127, 10, 100, 0);
    run_phase(1, 85, 200, 40);
    run_phase(0, 0, 80, 0);
    run_phase(8, 10, 300, 0);
    run_phase(65, 0, 60, 0);
    run_phase(3, 85, 250, 0);
    run_phase(16, 0, 300, 0);
    run_phase($urandom_range(127, 1), 10, 150, 0);
    run_phase(5, 0, 190, 0);

    drain();
    repeat (70) @(posedge clk);
    $display("Covered %0d region writes and %0d lookups: %0d exact, %0d nearest-key, %0d empty.",
             sb.writes, sb.queries, sb.exact_hits, sb.fallbacks, sb.empties);
    $display("Region counts 0 to 127 including above table depth; sender idle 0, 10, 85 percent.");
    if (sb.mismatches == 0 && sb.pending_lookups.size() == 0) begin
      $display("key_velocity_region_lookup_tb OK");
    end else begin
      $display("key_velocity_region_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kvrl_pkg.sv
rtl/core/kvrl_ram.sv
rtl/core/kvrl_ctrl.sv
rtl/core/kvrl_dp.sv
rtl/core/key_velocity_region_lookup.sv
dv/key_velocity_region_lookup_tb.sv
